>>> rtl/gbc_pkg.sv
// shared types and constants of the gyro bias calibrator
package gbc_pkg;

  // axes handled by the block
  localparam int NUM_AXES = 3;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int CAL_W = 16;
  localparam logic REG_CAL_SAMPLES = 1'b0;
  localparam logic [CAL_W-1:0] CAL_SAMPLES_RESET = 16'd1024;

  // sample counter and divisor width
  localparam int COUNT_W = 16;

  typedef enum logic [1:0] {
    AXIS_ROLL,
    AXIS_PITCH,
    AXIS_YAW
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_SUB,
    ST_OUT
  } state_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic load_add;
    logic load_sub;
    logic step;
    logic off_we;
  } lane_ctl_t;

endpackage

>>> rtl/gbc_serial_lane.sv
// one axis lane: bit-serial accumulator / subtractor with its offset register
module gbc_serial_lane #(
  parameter int SB = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gbc_pkg::lane_ctl_t    ctl,
  input  logic signed [SB-1:0]  sample,
  input  logic signed [SB-1:0]  off_value,
  output logic [SB+15:0]        acc_out
);
  import gbc_pkg::*;

  localparam int W = SB + COUNT_W;
  localparam int EXT = W - SB;

  logic [W-1:0]  acc;
  logic [W-1:0]  opd;
  logic [SB-1:0] offset;
  logic          carry;
  logic          sub_mode;
  logic          b_bit;
  logic          s_bit;
  logic          c_next;

  // one full-adder slice, operand inverted when subtracting
  always_comb begin
    b_bit  = opd[0] ^ sub_mode;
    s_bit  = acc[0] ^ b_bit ^ carry;
    c_next = (acc[0] & b_bit) | (acc[0] & carry) | (b_bit & carry);
  end

  // running sum (later the difference) and offset
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      offset <= '0;
    end else begin
      if (ctl.off_we) begin
        offset <= off_value;
      end
      if (ctl.load_sub) begin
        acc <= {{EXT{sample[SB-1]}}, sample};
      end else if (ctl.step) begin
        acc <= {s_bit, acc[W-1:1]};
      end
    end
  end

  // operand shift register, arithmetic shift keeps the sign
  always_ff @(posedge clk) begin
    if (ctl.load_sub) begin
      opd      <= {{EXT{offset[SB-1]}}, offset};
      carry    <= 1'b1;
      sub_mode <= 1'b1;
    end else if (ctl.load_add) begin
      opd      <= {{EXT{sample[SB-1]}}, sample};
      carry    <= 1'b0;
      sub_mode <= 1'b0;
    end else if (ctl.step) begin
      opd   <= {opd[W-1], opd[W-1:1]};
      carry <= c_next;
    end
  end

  assign acc_out = acc;

endmodule

>>> rtl/gbc_divider.sv
// shared restoring divider, one quotient bit per cycle, truncates toward zero
module gbc_divider #(
  parameter int SB = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [SB+15:0]                 dividend,
  input  logic [gbc_pkg::COUNT_W-1:0]    divisor,
  output logic                           done,
  output logic [SB-1:0]                  quotient
);
  import gbc_pkg::*;

  localparam int DW = SB + COUNT_W;
  localparam int CW = $clog2(DW);

  logic [DW-1:0]      dvd;
  logic [COUNT_W-1:0] rem;
  logic [CW-1:0]      cnt;
  logic               running;
  logic               neg;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   diff;
  logic               ge;
  logic [SB-1:0]      q_mag;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem, dvd[DW-1]};
    diff   = rem_sh - {1'b0, divisor};
    ge     = rem_sh >= {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && (cnt == CW'(DW - 1));
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        if (cnt == CW'(DW - 1)) begin
          running <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // magnitude divide, quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1];
      dvd <= dividend[DW-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
    end else if (running) begin
      rem <= ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
      dvd <= {dvd[DW-2:0], ge};
    end
  end

  // restore the sign; the mean always fits the sample width
  assign q_mag    = dvd[SB-1:0];
  assign quotient = neg ? (~q_mag + 1'b1) : q_mag;

endmodule

>>> rtl/gyro_bias_calibrator_unit.sv
// top level of the gyro zero-rate bias calibrator
//
//  port group   dir  handshake             payload
//  ----------   ---  --------------------  ------------------------------------
//  input word   in   in_valid / in_ready   rate_roll, rate_pitch, rate_yaw
//  output word  out  out_valid / out_ready corrected_roll/_pitch/_yaw
//  config       in   psel/penable/pwrite   paddr, pwdata -> prdata, pready
//
//  the lanes are W = SAMPLE_BITS + 16 bits wide; a calibration word is added bit
//  by bit in the three bit-serial lanes, the word that ends calibration then
//  runs the shared divider for each axis in turn, one divider step per cycle,
//  and a correction word is subtracted bit by bit in the lanes' one-bit adders.
//  reset is synchronous; the block restarts calibration with zero sums.
//  a stalled output word holds in its register while the next word is worked on.
module gyro_bias_calibrator_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [SAMPLE_BITS-1:0]    rate_roll,
  input  logic signed [SAMPLE_BITS-1:0]    rate_pitch,
  input  logic signed [SAMPLE_BITS-1:0]    rate_yaw,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_BITS:0]      corrected_roll,
  output logic signed [SAMPLE_BITS:0]      corrected_pitch,
  output logic signed [SAMPLE_BITS:0]      corrected_yaw,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gbc_pkg::PADDR_W-1:0]      paddr,
  input  logic [gbc_pkg::PDATA_W-1:0]      pwdata,
  output logic [gbc_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import gbc_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int W = SB + COUNT_W;
  localparam int CW = $clog2(W);

  state_t             state;
  state_t             state_next;
  axis_t              axis;
  logic [CW-1:0]      cnt;
  logic [CAL_W-1:0]   cal_samples;
  logic [COUNT_W-1:0] seen;
  logic               is_ready;
  logic               finish;
  logic               accept;
  logic               last_bit;
  logic               out_load;
  logic               div_start;
  logic               div_done;
  logic [SB-1:0]      div_q;
  logic [COUNT_W-1:0] target;
  logic [COUNT_W-1:0] seen_inc;
  logic               cfg_we;
  lane_ctl_t          lane_ctl [NUM_AXES];
  logic [SB-1:0]      lane_in  [NUM_AXES];
  logic [W-1:0]       lane_acc [NUM_AXES];

  // configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[PADDR_W-1:2] == REG_CAL_SAMPLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_samples <= CAL_SAMPLES_RESET;
    end else if (cfg_we) begin
      cal_samples <= pwdata[CAL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_CAL_SAMPLES) begin
      prdata = {{(PDATA_W - CAL_W){1'b0}}, cal_samples};
    end
  end

  // a count of zero acts as one
  assign target   = (cal_samples == '0) ? COUNT_W'(1) : cal_samples;
  assign seen_inc = seen + 1'b1;
  assign last_bit = (cnt == CW'(W - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = is_ready ? ST_SUB : ST_ACC;
        end
      end
      ST_ACC: begin
        if (last_bit) begin
          state_next = finish ? ST_DIV_LOAD : ST_IDLE;
        end
      end
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = (axis == AXIS_YAW) ? ST_IDLE : ST_DIV_LOAD;
        end
      end
      ST_SUB: begin
        if (last_bit) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = (state == ST_IDLE);
    accept    = in_valid && (state == ST_IDLE);
    div_start = (state == ST_DIV_LOAD);
    out_load  = (state == ST_OUT) && (!out_valid || out_ready);
    for (int a = 0; a < NUM_AXES; a++) begin
      lane_ctl[a].load_add = accept && !is_ready;
      lane_ctl[a].load_sub = accept && is_ready;
      lane_ctl[a].step     = (state == ST_ACC) || (state == ST_SUB);
      lane_ctl[a].off_we   = (state == ST_DIV) && div_done && (axis == axis_t'(a));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      axis     <= AXIS_ROLL;
      cnt      <= '0;
      seen     <= '0;
      is_ready <= 1'b0;
      finish   <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_ACC) || (state == ST_SUB)) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
      if (accept) begin
        axis <= AXIS_ROLL;
        if (!is_ready) begin
          seen   <= seen_inc;
          finish <= (seen_inc >= target);
        end
      end
      if ((state == ST_DIV) && div_done) begin
        if (axis == AXIS_YAW) begin
          is_ready <= 1'b1;
        end else begin
          axis <= axis_t'(axis + 1'b1);
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      corrected_roll  <= lane_acc[AXIS_ROLL][SB:0];
      corrected_pitch <= lane_acc[AXIS_PITCH][SB:0];
      corrected_yaw   <= lane_acc[AXIS_YAW][SB:0];
    end
  end

  // axis lanes
  assign lane_in[AXIS_ROLL]  = rate_roll;
  assign lane_in[AXIS_PITCH] = rate_pitch;
  assign lane_in[AXIS_YAW]   = rate_yaw;

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    gbc_serial_lane #(
      .SB (SB)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (lane_ctl[g]),
      .sample    (lane_in[g]),
      .off_value (div_q),
      .acc_out   (lane_acc[g])
    );
  end

  // shared divider, one axis after another
  gbc_divider #(
    .SB (SB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (lane_acc[axis]),
    .divisor  (seen),
    .done     (div_done),
    .quotient (div_q)
  );

  // checks
  a_no_out_while_cal: assert property (@(posedge clk) disable iff (rst)
    !is_ready |-> !out_valid)
    else $error("output word while calibrating");

  a_div_only_cal: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_LOAD) |-> !is_ready)
    else $error("divider started after calibration");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider result outside divide phase");

  a_ready_to_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(is_ready) |-> (state == ST_IDLE) && (axis == AXIS_YAW))
    else $error("calibration ended in wrong phase");

endmodule
